/* hdl/base64_symbol_bit_packer_unit_assert.svh */
// Assertion macros shared by the checker of the base64 symbol bit packer.
// Depends on nothing; every macro samples on the rising edge of clock.
`ifndef BASE64_SYMBOL_BIT_PACKER_UNIT_ASSERT_SVH
`define BASE64_SYMBOL_BIT_PACKER_UNIT_ASSERT_SVH

// Clocked assertion that is switched off while reset is high.
`define B64BP_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Clocked assertion that is also checked across reset.
`define B64BP_ASSERT_RST(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

/* hdl/b64bp_pkg.sv */
// Package of the base64 symbol bit packer: payload types, work item type,
// command codes and the base64 symbol decode function. Depends on nothing.
package b64bp_pkg;

   // Default depth of the queue between front and back.
   localparam int QUEUE_DEPTH_DEF = 2;

   // Input command codes.
   typedef enum logic [1:0] {
      CMD_CHAR  = 2'd0,
      CMD_RAW   = 2'd1,
      CMD_PAD   = 2'd2,
      CMD_FLUSH = 2'd3
   } cmd_type;

   // Operations that the front hands to the back.
   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_BAD    = 2'd1,
      OP_FLUSH  = 2'd2
   } op_type;

   typedef struct packed {
      logic [1:0] command;
      logic [7:0] data;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       bad_symbol;
      logic       final_res;
   } rsp_type;

   // Classified item: value is zero above its nbits low bits.
   typedef struct packed {
      op_type     op;
      logic [7:0] value;
      logic [3:0] nbits;
   } work_type;

   // Symbol decode result.
   typedef struct packed {
      logic       valid;
      logic [5:0] index;
   } sym_type;

   // Maps an ASCII code to its 6-bit base64 index.
   function automatic sym_type sym_index(input logic [7:0] c);
      sym_type    s;
      logic [7:0] t;
      s = '0;
      t = '0;
      if (c >= 8'd65 && c <= 8'd90) begin
         t = c - 8'd65;
         s = '{valid: 1'b1, index: t[5:0]};
      end else if (c >= 8'd97 && c <= 8'd122) begin
         t = c - 8'd71;
         s = '{valid: 1'b1, index: t[5:0]};
      end else if (c >= 8'd48 && c <= 8'd57) begin
         t = c + 8'd4;
         s = '{valid: 1'b1, index: t[5:0]};
      end else if (c == 8'd43) begin
         s = '{valid: 1'b1, index: 6'd62};
      end else if (c == 8'd47) begin
         s = '{valid: 1'b1, index: 6'd63};
      end
      return s;
   endfunction

endpackage

/* hdl/base64_symbol_bit_packer_unit.sv */
// Top level of the base64 symbol bit packer: front, queue and back.
// Depends on b64bp_pkg, b64bp_front, b64bp_queue and b64bp_back.
//
// Usage:
//   The request channel (req_valid, req_ready, req_payload) carries one
//   command per transaction: a base64 character, a raw byte, a four-bit
//   zero pad or a flush. The response channel (rsp_valid, rsp_ready,
//   rsp_payload) carries each completed byte, a bad-symbol marker for an
//   unmapped character, or the final partial byte produced by a flush.
//   Bits pack least significant first.
//   Throughput is one request per clock cycle, set by the packing step in
//   the back end, while the receiver keeps rsp_ready high. A response
//   passes the classifying front register, then a queue entry, then the
//   response register before it appears on rsp_valid.
//   When the receiver holds rsp_ready low, the response register holds its
//   transaction, the queue fills behind it, and req_ready falls once the
//   front register and the queue are both full; nothing is dropped.
//   A synchronous reset empties the front register, the queue and the
//   response register and clears the pending bits and bit count to zero.
module base64_symbol_bit_packer_unit import b64bp_pkg::*; #(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_payload
);

   logic     push_valid, push_ready;
   work_type push_item;
   logic     pop_valid, pop_ready;
   work_type pop_item;

   b64bp_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .push_valid  (push_valid),
      .push_ready  (push_ready),
      .push_item   (push_item)
   );

   b64bp_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item)
   );

   b64bp_back u_back (
      .clock       (clock),
      .reset       (reset),
      .pop_valid   (pop_valid),
      .pop_ready   (pop_ready),
      .pop_item    (pop_item),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

/* hdl/b64bp_front.sv */
// Front of the base64 symbol bit packer: accepts request transactions and
// classifies them into work items. Depends on b64bp_pkg.
module b64bp_front import b64bp_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  req_type  req_payload,
   output logic     push_valid,
   input  logic     push_ready,
   output work_type push_item
);

   logic     valid_ff, valid_in;
   work_type item_ff, item_in;
   work_type classified;
   sym_type  sym;
   logic     accept;

   // The stage takes a new transaction when empty or when it drains now.
   assign req_ready = !valid_ff || push_ready;
   assign accept    = req_valid && req_ready;

   // Classification of the incoming command.
   always_comb begin
      sym        = sym_index(req_payload.data);
      classified = '{op: OP_INSERT, value: 8'd0, nbits: 4'd0};
      unique case (cmd_type'(req_payload.command))
         CMD_CHAR: begin
            if (sym.valid) begin
               classified = '{op: OP_INSERT, value: {2'b00, sym.index}, nbits: 4'd6};
            end else begin
               classified = '{op: OP_BAD, value: 8'd0, nbits: 4'd0};
            end
         end
         CMD_RAW: begin
            classified = '{op: OP_INSERT, value: req_payload.data, nbits: 4'd8};
         end
         CMD_PAD: begin
            classified = '{op: OP_INSERT, value: 8'd0, nbits: 4'd4};
         end
         CMD_FLUSH: begin
            classified = '{op: OP_FLUSH, value: 8'd0, nbits: 4'd0};
         end
         default: begin
            classified = '{op: OP_FLUSH, value: 8'd0, nbits: 4'd0};
         end
      endcase
   end

   // Stage register next values.
   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (accept) begin
         valid_in = 1'b1;
         item_in  = classified;
      end else if (push_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign push_valid = valid_ff;
   assign push_item  = item_ff;

endmodule

/* hdl/b64bp_queue.sv */
// Short queue of work items between the front and the back of the packer.
// Depends on b64bp_pkg.
module b64bp_queue import b64bp_pkg::*; #(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     push_valid,
   output logic     push_ready,
   input  work_type push_item,
   output logic     pop_valid,
   input  logic     pop_ready,
   output work_type pop_item
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

   work_type         entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push, pop;

   assign push_ready = (count_ff != FULL_CNT);
   assign pop_valid  = (count_ff != '0);
   assign pop_item   = entry_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

/* hdl/b64bp_back.sv */
// Back of the base64 symbol bit packer: packs work items into bytes and
// holds the response register. Depends on b64bp_pkg.
module b64bp_back import b64bp_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     pop_valid,
   output logic     pop_ready,
   input  work_type pop_item,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   output rsp_type  rsp_payload
);

   logic [6:0]  partial_ff, partial_in;
   logic [2:0]  count_ff, count_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_ff, rsp_in;
   logic        take;
   logic [3:0]  total;
   logic [3:0]  rest;
   logic [14:0] combined;

   // A new item is taken when the response register is free or drains now.
   assign pop_ready = !rsp_valid_ff || rsp_ready;
   assign take      = pop_valid && pop_ready;

   // New bits land above the pending ones; total counts both.
   assign total    = {1'b0, count_ff} + pop_item.nbits;
   assign rest     = total - 4'd8;
   assign combined = {8'd0, partial_ff} | ({7'd0, pop_item.value} << count_ff);

   // Packing state and response next values.
   always_comb begin
      partial_in   = partial_ff;
      count_in     = count_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (take) begin
         unique case (pop_item.op)
            OP_INSERT: begin
               if (total >= 4'd8) begin
                  partial_in   = combined[14:8];
                  count_in     = rest[2:0];
                  rsp_in       = '{out_byte: combined[7:0], bad_symbol: 1'b0,
                                   final_res: 1'b0};
                  rsp_valid_in = 1'b1;
               end else begin
                  partial_in = combined[6:0];
                  count_in   = total[2:0];
               end
            end
            OP_BAD: begin
               partial_in   = '0;
               count_in     = '0;
               rsp_in       = '{out_byte: 8'd0, bad_symbol: 1'b1, final_res: 1'b0};
               rsp_valid_in = 1'b1;
            end
            OP_FLUSH: begin
               // A flush with nothing pending leaves no response.
               if (count_ff != '0) begin
                  rsp_in       = '{out_byte: {1'b0, partial_ff}, bad_symbol: 1'b0,
                                   final_res: 1'b1};
                  rsp_valid_in = 1'b1;
               end
               partial_in = '0;
               count_in   = '0;
            end
            default: begin
               partial_in = partial_ff;
               count_in   = count_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         partial_ff   <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         partial_ff   <= partial_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

/* hdl/b64bp_checker.sv */
// Port-level checker of the base64 symbol bit packer and its bind.
// Depends on b64bp_pkg and base64_symbol_bit_packer_unit_assert.svh.
`include "base64_symbol_bit_packer_unit_assert.svh"

module b64bp_checker import b64bp_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input req_type req_payload,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_payload
);

   logic req_stall;
   logic rsp_stall;
   logic rsp_bad;
   logic rsp_final;
   logic rsp_bad_clean;

   // Handshake and payload conditions the assertions look at.
   assign req_stall     = req_valid && !req_ready;
   assign rsp_stall     = rsp_valid && !rsp_ready;
   assign rsp_bad       = rsp_valid && rsp_payload.bad_symbol;
   assign rsp_final     = rsp_valid && rsp_payload.final_res;
   assign rsp_bad_clean = (rsp_payload.out_byte == 8'd0) && !rsp_payload.final_res;

   // A stalled request transaction holds its payload until it is taken.
   `B64BP_ASSERT(a_req_hold, req_stall |=> req_valid && $stable(req_payload), "request moved")

   // A stalled response transaction holds its payload.
   `B64BP_ASSERT(a_rsp_hold, rsp_stall |=> rsp_valid && $stable(rsp_payload), "response moved")

   // A bad-symbol response carries no byte and no final mark.
   `B64BP_ASSERT(a_bad_clean, rsp_bad |-> rsp_bad_clean, "bad-symbol response carries data")

   // A flushed partial byte never has its top bit set.
   `B64BP_ASSERT(a_final_msb, rsp_final |-> !rsp_payload.out_byte[7], "final byte has bit 7 set")

   // The cycle after reset is high, no response is offered.
   `B64BP_ASSERT_RST(a_reset_empty, reset |=> !rsp_valid, "response valid after reset")

endmodule

bind base64_symbol_bit_packer_unit b64bp_checker u_b64bp_checker (.*);

/* test/base64_symbol_bit_packer_unit_test.sv */
// Self-checking testbench of the base64 symbol bit packer unit.
// Depends on b64bp_pkg and base64_symbol_bit_packer_unit; it predicts every
// response in its own bit packing model and drives both channels with random idling.
module base64_symbol_bit_packer_unit_test;
   timeunit 1ns;
   timeprecision 1ps;
   import b64bp_pkg::*;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int HOLD_CYCLES    = 200;
   localparam int DRAIN_CYCLES   = 10;
   localparam int REPORT_LIMIT   = 10;

   logic    clock       = 1'b0;
   logic    reset       = 1'b1;
   logic    req_valid   = 1'b0;
   logic    req_ready;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_ready   = 1'b0;
   rsp_type rsp_payload;

   // Idle rates in percent of cycles, and a receiver hold-off request.
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_request  = 0;
   int hold_left     = 0;

   // Bookkeeping for the checker, the watchdog and the summary.
   rsp_type expected_rsp_q[$];
   rsp_type want_rsp;
   int      mismatch_count = 0;
   int      stall_cycles   = 0;
   int      items_sent     = 0;
   int      rsp_seen       = 0;
   int      bad_seen       = 0;
   int      final_seen     = 0;

   // Bits still waiting to fill the next byte in the model.
   logic [6:0] pend_bits  = '0;
   logic [2:0] pend_count = '0;

   base64_symbol_bit_packer_unit u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   // Free-running clock with a 10 ns period.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Maps a character to {not_a_symbol, index}.
   function automatic logic [6:0] decode_symbol(input logic [7:0] c);
      logic [7:0] idx;
      if (c >= "A" && c <= "Z") begin
         idx = c - "A";
      end else if (c >= "a" && c <= "z") begin
         idx = c - "a" + 8'd26;
      end else if (c >= "0" && c <= "9") begin
         idx = c - "0" + 8'd52;
      end else if (c == "+") begin
         idx = 8'd62;
      end else if (c == "/") begin
         idx = 8'd63;
      end else begin
         idx = 8'd64;
      end
      return {idx[6], idx[5:0]};
   endfunction

   // Maps a 6-bit index back to its character, for building streams.
   function automatic logic [7:0] symbol_char(input logic [5:0] idx);
      if (idx < 6'd26) begin
         return "A" + idx;
      end else if (idx < 6'd52) begin
         return "a" + (idx - 6'd26);
      end else if (idx < 6'd62) begin
         return "0" + (idx - 6'd52);
      end else if (idx == 6'd62) begin
         return "+";
      end
      return "/";
   endfunction

   // Advances the packing model by one transaction; returns 1 with a response.
   function automatic logic predict_step(input req_type item, output rsp_type res);
      logic [6:0]  sym;
      logic [7:0]  val;
      logic [3:0]  nbits;
      logic [3:0]  total;
      logic [15:0] merged;
      res   = '0;
      val   = '0;
      nbits = 4'd0;
      case (cmd_type'(item.command))
         CMD_CHAR: begin
            sym = decode_symbol(item.data);
            // An unmapped character restarts the stream.
            if (sym[6]) begin
               pend_bits      = '0;
               pend_count     = '0;
               res.bad_symbol = 1'b1;
               return 1'b1;
            end
            val   = {2'b00, sym[5:0]};
            nbits = 4'd6;
         end
         CMD_RAW: begin
            val   = item.data;
            nbits = 4'd8;
         end
         CMD_PAD: begin
            nbits = 4'd4;
         end
         CMD_FLUSH: begin
            if (pend_count == 3'd0) begin
               return 1'b0;
            end
            res.out_byte  = {1'b0, pend_bits};
            res.final_res = 1'b1;
            pend_bits     = '0;
            pend_count    = '0;
            return 1'b1;
         end
      endcase
      merged = {9'd0, pend_bits} | ({8'd0, val} << pend_count);
      total  = {1'b0, pend_count} + nbits;
      // The total never exceeds 15, so its low three bits are the leftover count.
      pend_count = total[2:0];
      if (total >= 4'd8) begin
         res.out_byte = merged[7:0];
         pend_bits    = merged[14:8];
         return 1'b1;
      end
      pend_bits = merged[6:0];
      return 1'b0;
   endfunction

   // Offers one transaction, waits for its acceptance and records the prediction.
   task automatic send_item(input cmd_type cmd, input logic [7:0] data);
      req_type item;
      rsp_type res;
      item.command = cmd;
      item.data    = data;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (!req_ready);
      items_sent++;
      if (predict_step(item, res)) begin
         expected_rsp_q.push_back(res);
      end
   endtask

   // Stops offering and waits until every predicted response has come back.
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_rsp_q.size() != 0);
   endtask

   // Sends one mostly well-formed stream, usually closed by a flush.
   task automatic send_stream(output int count);
      int         len;
      int         roll;
      logic [7:0] c;
      logic [6:0] sym;
      len   = $urandom_range(1, 24);
      count = len;
      for (int i = 0; i < len; i++) begin
         roll = $urandom_range(0, 99);
         if (roll < 78) begin
            send_item(CMD_CHAR, symbol_char(6'($urandom_range(0, 63))));
         end else if (roll < 88) begin
            send_item(CMD_RAW, 8'($urandom_range(0, 255)));
         end else if (roll < 95) begin
            send_item(CMD_PAD, 8'($urandom_range(0, 255)));
         end else begin
            do begin
               c   = 8'($urandom_range(0, 255));
               sym = decode_symbol(c);
            end while (!sym[6]);
            send_item(CMD_CHAR, c);
         end
      end
      if ($urandom_range(0, 99) < 85) begin
         send_item(CMD_FLUSH, 8'($urandom_range(0, 255)));
         count++;
      end
   endtask

   // Field extremes, every command and each corner of the packing rules.
   task automatic test_directed();
      send_item(CMD_FLUSH, 8'h00);  // nothing pending: no response
      send_item(CMD_CHAR, "A");
      send_item(CMD_CHAR, "/");
      send_item(CMD_CHAR, "+");
      send_item(CMD_CHAR, "Z");
      send_item(CMD_CHAR, "a");
      send_item(CMD_CHAR, "z");
      send_item(CMD_CHAR, "0");
      send_item(CMD_CHAR, "9");
      send_item(CMD_FLUSH, 8'h00);
      send_item(CMD_RAW, 8'h00);
      send_item(CMD_RAW, 8'hFF);
      send_item(CMD_CHAR, "/");
      send_item(CMD_PAD, 8'h00);    // pad completes a byte, two bits remain
      send_item(CMD_FLUSH, 8'h00);
      send_item(CMD_CHAR, "Q");
      send_item(CMD_CHAR, "=");     // bad character clears pending bits
      send_item(CMD_FLUSH, 8'h00);
      send_item(CMD_CHAR, 8'h80);   // codes above 127 are never symbols
      send_item(CMD_CHAR, 8'hFF);
      send_item(CMD_CHAR, 8'h00);
      send_item(CMD_RAW, 8'hA5);
      send_item(CMD_PAD, 8'hFF);
      send_item(CMD_PAD, 8'h00);
      send_item(CMD_FLUSH, 8'hFF);
   endtask

   // Random streams mixed with random noise transactions.
   task automatic test_random_streams(input int n_items, input int s_pct, input int r_pct);
      int sent;
      int cnt;
      send_idle_pct = s_pct;
      recv_idle_pct = r_pct;
      sent          = 0;
      while (sent < n_items) begin
         if ($urandom_range(0, 99) < 20) begin
            cnt = $urandom_range(1, 8);
            repeat (cnt) begin
               send_item(cmd_type'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
            end
         end else begin
            send_stream(cnt);
         end
         sent += cnt;
      end
   endtask

   // The receiver holds off while raw bytes keep coming, so the input stalls.
   task automatic test_backpressure();
      send_idle_pct = 0;
      hold_request  = HOLD_CYCLES;
      repeat (40) begin
         send_item(CMD_RAW, 8'($urandom_range(0, 255)));
      end
      wait_drained();
   endtask

   // The sender pauses after each stream until the unit has emptied.
   task automatic test_drain_pause();
      int cnt;
      repeat (8) begin
         send_stream(cnt);
         wait_drained();
      end
   endtask

   // Receiver: random ready, or a counted hold-off when one is requested.
   always @(posedge clock) begin
      if (hold_request > 0) begin
         hold_left    = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   // Compares each accepted response with the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         rsp_seen++;
         if (rsp_payload.bad_symbol) bad_seen++;
         if (rsp_payload.final_res) final_seen++;
         if (expected_rsp_q.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT) begin
               $display("%0t: response with nothing expected: byte %02h bad %0b final %0b",
                        $realtime, rsp_payload.out_byte, rsp_payload.bad_symbol,
                        rsp_payload.final_res);
            end
         end else begin
            want_rsp = expected_rsp_q.pop_front();
            if (rsp_payload.out_byte !== want_rsp.out_byte
                || rsp_payload.bad_symbol !== want_rsp.bad_symbol
                || rsp_payload.final_res !== want_rsp.final_res) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT) begin
                  $display("%0t: expected byte %02h bad %0b final %0b, got byte %02h bad %0b final %0b",
                           $realtime, want_rsp.out_byte, want_rsp.bad_symbol,
                           want_rsp.final_res, rsp_payload.out_byte,
                           rsp_payload.bad_symbol, rsp_payload.final_res);
               end
            end
         end
      end
   end

   // Watchdog: ends the run when no transaction moves for too long.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles = 0;
      end else begin
         stall_cycles++;
      end
      if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("Timeout: no transaction for %0d cycles, %0d responses outstanding.",
                  WATCHDOG_LIMIT, expected_rsp_q.size());
         $display("[base64_symbol_bit_packer_unit] ERROR");
         $finish;
      end
   end

   // Test sequence.
   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      send_idle_pct = 31;
      recv_idle_pct = 63;
      test_directed();
      test_random_streams(540, 31, 63);
      test_drain_pause();
      test_random_streams(540, 63, 31);
      test_backpressure();
      test_random_streams(540, 0, 0);
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_rsp_q.size() != 0) begin
         mismatch_count++;
      end
      $display("Sent %0d requests: directed corners, random streams, noise, stalls and drains.",
               items_sent);
      $display("Checked %0d responses, %0d of them bad-symbol and %0d final; %0d failures.",
               rsp_seen, bad_seen, final_seen, mismatch_count);
      if (mismatch_count == 0) begin
         $display("[base64_symbol_bit_packer_unit] OK");
      end else begin
         $display("[base64_symbol_bit_packer_unit] ERROR");
      end
      $finish;
   end

endmodule
